// ----- rtl/core/vibe_background_subtractor_macros.svh -----
// Assertion macros for the ViBe background subtractor.
// Included by the top level; no other dependencies.
`ifndef VIBE_BACKGROUND_SUBTRACTOR_MACROS_SVH
`define VIBE_BACKGROUND_SUBTRACTOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define VBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define VBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/vbs_pkg.sv -----
// Package for the ViBe background subtractor: widths, codes, FSM type, tables.
// No dependencies.
package vbs_pkg;

  localparam int unsigned ImgWidthDef   = 64;
  localparam int unsigned ImgHeightDef  = 64;
  localparam int unsigned SampleSlots   = 16;

  localparam int unsigned PixW  = 8;
  localparam int unsigned PosW  = 6;
  localparam int unsigned SlotW = 4;
  localparam int unsigned PickW = 4;
  localparam int unsigned CntW  = 8;
  localparam int unsigned CfgW  = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgMinMatches = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRadius     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAbsorb     = 2'd2;

  localparam logic CmdLoad    = 1'b0;
  localparam logic CmdProcess = 1'b1;

  localparam logic [4:0] MinMatchesRst = 5'd2;
  localparam logic [7:0] RadiusRst     = 8'd20;
  localparam logic [7:0] AbsorbRst     = 8'd50;
  localparam logic [CntW-1:0] CntMax   = 8'd255;

  typedef enum logic [2:0] {
    StIdle,
    StClear,
    StRead,
    StCompare,
    StSelf,
    StNeigh,
    StOut
  } state_e;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic read;
    logic decide;
    logic wr_self;
    logic wr_neigh;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_load;
    logic self_we;
    logic neigh_we;
  } stat_t;

  typedef struct packed {
    logic            cmd;
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
    logic [PixW-1:0] pixel;
    logic [SlotW-1:0] slot_pick;
    logic [7:0]      self_draw;
    logic [7:0]      neigh_draw;
    logic [PickW-1:0] neigh_dy_pick;
    logic [PickW-1:0] neigh_dx_pick;
    logic [SlotW-1:0] neigh_slot;
  } in_item_t;

  typedef struct packed {
    logic            foreground;
    logic [PosW-1:0] out_col;
    logic [PosW-1:0] out_row;
    logic [CntW-1:0] fg_count;
  } out_item_t;

  // Offset table -1,0,1,-1,1,-1,0,1,0 as a 2-bit code: 0 minus, 1 zero, 2 plus.
  function automatic logic [1:0] offset_code(input logic [PickW-1:0] pick);
    logic [1:0] code;
    unique case (pick)
      4'd0, 4'd3, 4'd5: code = 2'd0;
      4'd2, 4'd4, 4'd7: code = 2'd2;
      default:          code = 2'd1;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/core/vbs_stream_if.sv -----
// Valid/ready channel carrying a parameterized payload.
// No dependencies.
interface vbs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/vibe_background_subtractor.sv -----
// ViBe background subtractor. A load item is written during its read step; a process
// item goes through read, compare, self write, neighbor write and output, one
// memory port serializing the write-backs; the next item is taken only after
// the result is taken.
// Reset: async low; config to defaults, then a clearing pass over all
// IMG_WIDTH*IMG_HEIGHT count entries zeroes the counts before the first item.
module vibe_background_subtractor #(
  parameter int unsigned IMG_WIDTH   = vbs_pkg::ImgWidthDef,
  parameter int unsigned IMG_HEIGHT  = vbs_pkg::ImgHeightDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  vbs_stream_if.sink                  in_if,
  vbs_stream_if.source                out_if,
  input  logic                        cfg_we_i,
  input  logic [vbs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [vbs_pkg::CfgW-1:0]    cfg_data_i
);
  import vbs_pkg::*;
  `include "vibe_background_subtractor_macros.svh"

  logic [4:0]      min_matches_q;
  logic [CfgW-1:0] radius_q, absorb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_matches_q <= MinMatchesRst;
      radius_q      <= RadiusRst;
      absorb_q      <= AbsorbRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinMatches: min_matches_q <= cfg_data_i[4:0];
        CfgRadius:     radius_q      <= cfg_data_i;
        CfgAbsorb:     absorb_q      <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  cmd_t  cmd;
  stat_t stat;

  vbs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vbs_datapath #(
    .IMG_WIDTH(IMG_WIDTH), .IMG_HEIGHT(IMG_HEIGHT)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .stat_o       (stat),
    .item_i       (in_if.data),
    .min_matches_i(min_matches_q),
    .radius_i     (radius_q),
    .absorb_i     (absorb_q),
    .result_o     (out_if.data)
  );

  `VBS_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, in_if.ready, !out_if.valid)
  `VBS_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_if.valid && !out_if.ready,
                   out_if.valid && $stable(out_if.data))
  `VBS_ASSERT_IMP(a_one_write, clk_i, rst_ni, cmd.wr_self, !cmd.wr_neigh)

endmodule

// ----- rtl/core/vbs_ctrl.sv -----
// Controller FSM: clearing pass, then read / compare / write-back per item.
// Depends on vbs_pkg.
module vbs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  vbs_pkg::stat_t stat_i,
  output vbs_pkg::cmd_t  cmd_o
);
  import vbs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear:   if (stat_i.clr_done) state_d = StIdle;
      StIdle:    if (in_valid_i) state_d = StRead;
      StRead:    state_d = stat_i.is_load ? StIdle : StCompare;
      StCompare: state_d = StSelf;
      StSelf:    state_d = StNeigh;
      StNeigh:   state_d = StOut;
      StOut:     if (out_ready_i) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StClear:   cmd_o.clr_step = 1'b1;
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      StRead:    cmd_o.read = 1'b1;
      StCompare: cmd_o.decide = 1'b1;
      StSelf:    cmd_o.wr_self = stat_i.self_we;
      StNeigh:   cmd_o.wr_neigh = stat_i.neigh_we;
      StOut:     out_valid_o = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

endmodule

// ----- rtl/core/vbs_datapath.sv -----
// Datapath: sample memory (one row of samples per pixel), count memory, compare.
// Depends on vbs_pkg.
module vbs_datapath #(
  parameter int unsigned IMG_WIDTH   = vbs_pkg::ImgWidthDef,
  parameter int unsigned IMG_HEIGHT  = vbs_pkg::ImgHeightDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vbs_pkg::cmd_t              cmd_i,
  output vbs_pkg::stat_t             stat_o,
  input  vbs_pkg::in_item_t          item_i,
  input  logic [4:0]                 min_matches_i,
  input  logic [vbs_pkg::CfgW-1:0]   radius_i,
  input  logic [vbs_pkg::CfgW-1:0]   absorb_i,
  output vbs_pkg::out_item_t         result_o
);
  import vbs_pkg::*;

  localparam int unsigned NPix  = IMG_WIDTH * IMG_HEIGHT;
  localparam int unsigned PixAW = (NPix > 1) ? $clog2(NPix) : 1;
  localparam int unsigned CW    = (IMG_WIDTH > 1) ? $clog2(IMG_WIDTH) : 1;
  localparam int unsigned RW    = (IMG_HEIGHT > 1) ? $clog2(IMG_HEIGHT) : 1;
  localparam int unsigned SW    = $clog2(SampleSlots);
  localparam int unsigned MW    = $clog2(SampleSlots + 1);

  // Sample memory: one word of all samples per pixel; byte writes.
  logic [SampleSlots-1:0][PixW-1:0] smem [NPix];
  logic [CntW-1:0] cmem [NPix];

  in_item_t item_q;
  logic [CW-1:0] c_q;
  logic [RW-1:0] r_q;
  logic [SW-1:0] slot_q, nslot_q;
  logic [PixAW-1:0] nidx_q;
  logic [SampleSlots-1:0][PixW-1:0] srow_q;
  logic [CntW-1:0] cnt_rd_q;
  logic fg_q;
  logic [CntW-1:0] cnt_q;
  logic self_we_q, neigh_we_q;
  logic [PixAW:0] clr_q;
  logic [MW-1:0] match_cnt;
  logic fg_d;
  logic [CntW-1:0] cnt_d;

  function automatic logic [SW-1:0] slot_wrap(input logic [SlotW-1:0] s);
    logic [31:0] w;
    w = 32'(s) % SampleSlots;
    return w[SW-1:0];
  endfunction

  function automatic logic [31:0] clamp(input logic [PosW-1:0] v, input int unsigned lim);
    logic [31:0] r;
    r = (32'(v) >= lim) ? 32'(lim - 1) : 32'(v);
    return r;
  endfunction

  function automatic logic [31:0] step(input logic [31:0] v, input logic [1:0] code,
                                       input int unsigned lim);
    logic [31:0] r;
    r = v;
    if (code == 2'd0 && v != 0) r = v - 1;
    else if (code == 2'd2 && v + 1 < lim) r = v + 1;
    return r;
  endfunction

  logic [31:0] cc, rc, nc, nr;
  always_comb begin
    cc = clamp(item_i.col, IMG_WIDTH);
    rc = clamp(item_i.row, IMG_HEIGHT);
    nc = step(cc, offset_code(item_i.neigh_dx_pick), IMG_WIDTH);
    nr = step(rc, offset_code(item_i.neigh_dy_pick), IMG_HEIGHT);
  end

  wire [PixAW-1:0] pidx = PixAW'(r_q * IMG_WIDTH + c_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q  <= item_i;
      c_q     <= cc[CW-1:0];
      r_q     <= rc[RW-1:0];
      slot_q  <= slot_wrap(item_i.slot_pick);
      nslot_q <= slot_wrap(item_i.neigh_slot);
      nidx_q  <= PixAW'(nr * IMG_WIDTH + nc);
    end
  end

  // Memory port: reads, load writes, count clear and count write-back, and the two sample write-backs.
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      srow_q   <= smem[pidx];
      cnt_rd_q <= cmem[pidx];
      if (item_q.cmd == CmdLoad) smem[pidx][slot_q] <= item_q.pixel;
    end
    if (cmd_i.clr_step) cmem[clr_q[PixAW-1:0]] <= '0;
    if (cmd_i.decide) cmem[pidx] <= cnt_d;
    if (cmd_i.wr_self) smem[pidx][slot_q] <= item_q.pixel;
    if (cmd_i.wr_neigh) smem[nidx_q][nslot_q] <= item_q.pixel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_comb begin
    logic [PixW-1:0] d;
    match_cnt = '0;
    for (int k = 0; k < SampleSlots; k++) begin
      d = (srow_q[k] > item_q.pixel) ? srow_q[k] - item_q.pixel
                                     : item_q.pixel - srow_q[k];
      if (d < radius_i) match_cnt = match_cnt + 1'b1;
    end
    fg_d  = !(6'(match_cnt) >= 6'(min_matches_i));
    cnt_d = fg_d ? ((cnt_rd_q == CntMax) ? CntMax : cnt_rd_q + 1'b1) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      fg_q       <= fg_d;
      cnt_q      <= cnt_d;
      self_we_q  <= fg_d ? (cnt_d > absorb_i) : (item_q.self_draw == 8'd0);
      neigh_we_q <= !fg_d && (item_q.neigh_draw == 8'd0);
    end
  end

  assign stat_o.clr_done = (clr_q == (PixAW+1)'(NPix - 1));
  assign stat_o.is_load  = (item_q.cmd == CmdLoad);
  assign stat_o.self_we  = self_we_q;
  assign stat_o.neigh_we = neigh_we_q;

  assign result_o.foreground = fg_q;
  assign result_o.out_col    = PosW'(c_q);
  assign result_o.out_row    = PosW'(r_q);
  assign result_o.fg_count   = cnt_q;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for vibe_background_subtractor: a per-pixel model predicts
// each classification; the valid/ready channels are driven with random idle gaps.
// Depends on vbs_pkg and vbs_stream_if from the RTL.
`timescale 1ns / 100ps

class vibe_scoreboard;
  logic [7:0] samples[65536];
  logic [7:0] fg_counts[4096];
  logic [4:0] min_matches;
  logic [7:0] radius;
  logic [7:0] absorb;
  vbs_pkg::out_item_t expected_q[$];
  int errors;
  int n_in;

  function new();
    foreach (fg_counts[i]) fg_counts[i] = '0;
    foreach (samples[i]) samples[i] = '0;
    min_matches = vbs_pkg::MinMatchesRst;
    radius = vbs_pkg::RadiusRst;
    absorb = vbs_pkg::AbsorbRst;
    errors = 0;
    n_in = 0;
  endfunction

  function void set_cfg(logic [4:0] mm, logic [7:0] rad, logic [7:0] ab);
    min_matches = mm;
    radius = rad;
    absorb = ab;
  endfunction

  function int offset_of(logic [3:0] pick);
    int tbl[9] = '{-1, 0, 1, -1, 1, -1, 0, 1, 0};
    return tbl[(pick > 8) ? 8 : pick];
  endfunction

  function logic [5:0] clamp63(int v);
    if (v < 0) return 6'd0;
    if (v > 63) return 6'd63;
    return v[5:0];
  endfunction

  // Apply one accepted transaction to the model and queue its classification.
  function void note_input(vbs_pkg::in_item_t it);
    logic [5:0] nr, nc;
    logic [7:0] cnt, s, d;
    int hit_cnt;
    bit fg;
    vbs_pkg::out_item_t res;
    n_in++;
    if (it.cmd == vbs_pkg::CmdLoad) begin
      samples[{it.row, it.col, it.slot_pick}] = it.pixel;
      return;
    end
    hit_cnt = 0;
    for (int k = 0; k < 16; k++) begin
      s = samples[{it.row, it.col, 4'(k)}];
      d = (s > it.pixel) ? s - it.pixel : it.pixel - s;
      if (d < radius) hit_cnt++;
    end
    fg = !(hit_cnt >= min_matches);
    if (!fg) begin
      cnt = '0;
      if (it.self_draw == 0) samples[{it.row, it.col, it.slot_pick}] = it.pixel;
      if (it.neigh_draw == 0) begin
        nr = clamp63(int'(it.row) + offset_of(it.neigh_dy_pick));
        nc = clamp63(int'(it.col) + offset_of(it.neigh_dx_pick));
        samples[{nr, nc, it.neigh_slot}] = it.pixel;
      end
    end else begin
      cnt = fg_counts[{it.row, it.col}];
      if (cnt != vbs_pkg::CntMax) cnt++;
      if (cnt > absorb) samples[{it.row, it.col, it.slot_pick}] = it.pixel;
    end
    fg_counts[{it.row, it.col}] = cnt;
    res.foreground = fg;
    res.out_col = it.col;
    res.out_row = it.row;
    res.fg_count = cnt;
    expected_q.push_back(res);
  endfunction

  function void check(vbs_pkg::out_item_t got);
    vbs_pkg::out_item_t exp_res;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: unexpected result %p", got);
      return;
    end
    exp_res = expected_q.pop_front();
    if (got.foreground !== exp_res.foreground || got.out_col !== exp_res.out_col ||
        got.out_row !== exp_res.out_row || got.fg_count !== exp_res.fg_count) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: mismatch fg %0d/%0d col %0d/%0d row %0d/%0d cnt %0d/%0d (exp/act)",
                 exp_res.foreground, got.foreground, exp_res.out_col, got.out_col,
                 exp_res.out_row, got.out_row, exp_res.fg_count, got.fg_count);
    end
  endfunction
endclass

module testbench;
  import vbs_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  vbs_stream_if #(.payload_t(in_item_t)) in_if ();
  vbs_stream_if #(.payload_t(out_item_t)) out_if ();

  vibe_background_subtractor u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  vibe_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit did_hold = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  // Pixels whose 16 slots are all loaded; only these get classified.
  int pix_list[$];
  logic [7:0] pix_base[4096];

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Receiver: random stall bursts plus one long hold-off mid-run.
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) sb.check(out_if.data);
    if (!did_hold && sb.n_in >= 700) begin
      did_hold = 1'b1;
      stall_left = 300;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(in_item_t it);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(it);
  endtask

  task automatic write_cfg(logic [4:0] mm, logic [7:0] rad, logic [7:0] ab);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgMinMatches;
    cfg_data_i <= CfgW'(mm);
    @(posedge clk_i);
    cfg_idx_i <= CfgRadius;
    cfg_data_i <= rad;
    @(posedge clk_i);
    cfg_idx_i <= CfgAbsorb;
    cfg_data_i <= ab;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_cfg(mm, rad, ab);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [7:0] near(logic [7:0] b, int spread);
    int v;
    v = int'(b) + $urandom_range(0, 2 * spread) - spread;
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic in_item_t rand_item(int p);
    in_item_t it;
    it.cmd = CmdProcess;
    it.row = p[11:6];
    it.col = p[5:0];
    it.pixel = ($urandom_range(0, 5) == 0) ? 8'($urandom) : near(pix_base[p], 30);
    it.slot_pick = 4'($urandom);
    it.self_draw = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
    it.neigh_draw = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
    it.neigh_dy_pick = 4'($urandom);
    it.neigh_dx_pick = 4'($urandom);
    it.neigh_slot = 4'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      it.cmd = CmdLoad;
      it.pixel = near(pix_base[p], 25);
    end
    return it;
  endfunction

  task automatic run_phase(int n, int focus);
    int p;
    for (int i = 0; i < n; i++) begin
      p = (focus >= 0) ? focus : pix_list[$urandom_range(0, pix_list.size() - 1)];
      send(rand_item(p));
    end
  endtask

  initial begin
    in_item_t it;
    int p;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgMinMatches;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_cfg(MinMatchesRst, RadiusRst, AbsorbRst);

    // Corners, edges and a dense cluster so neighbor writes overlap.
    pix_list = '{0, 63, 63 * 64, 4095, 32, 31 * 64 + 63, 63 * 64 + 17, 10 * 64};
    for (int r = 29; r <= 31; r++)
      for (int c = 29; c <= 31; c++) pix_list.push_back(r * 64 + c);
    foreach (pix_list[i]) begin
      p = pix_list[i];
      pix_base[p] = 8'($urandom);
      if (i == 0) pix_base[p] = 8'd0;
      if (i == 3) pix_base[p] = 8'd255;
      for (int s = 0; s < 16; s++) begin
        it = '0;
        it.cmd = CmdLoad;
        it.row = p[11:6];
        it.col = p[5:0];
        it.slot_pick = 4'(s);
        it.pixel = near(pix_base[p], 25);
        send(it);
      end
    end

    // Directed: extreme values, clamped neighbors, large picks, shared slot.
    for (int i = 0; i < 20; i++) begin
      it = rand_item(pix_list[i % 4]);
      it.cmd = CmdProcess;
      it.pixel = (i % 2) ? 8'd255 : 8'd0;
      it.self_draw = (i < 10) ? 8'd0 : 8'd255;
      it.neigh_draw = (i % 3 == 2) ? 8'd255 : 8'd0;
      it.neigh_dy_pick = (i < 5) ? 4'd0 : (i < 10) ? 4'd2 : 4'(9 + i % 7);
      it.neigh_dx_pick = (i < 5) ? 4'd3 : (i < 10) ? 4'd4 : 4'd15;
      it.slot_pick = (i < 4) ? 4'd15 : 4'(i);
      it.neigh_slot = (i % 4 == 1) ? it.slot_pick : 4'(15 - i % 16);
      send(it);
    end
    run_phase(200, -1);

    drain();
    write_cfg(5'd1, 8'd0, 8'd0);
    run_phase(60, -1);
    drain();
    write_cfg(5'd16, 8'd255, 8'd255);
    run_phase(150, -1);
    drain();
    write_cfg(5'd0, 8'd20, 8'd3);
    run_phase(100, -1);
    drain();
    write_cfg(5'd31, 8'd20, 8'd10);
    run_phase(80, -1);
    // Hammer one pixel toward count saturation; every process item is foreground.
    drain();
    write_cfg(5'd17, 8'd40, 8'd255);
    run_phase(260, pix_list[9]);
    for (int k = 0; k < 4; k++) begin
      drain();
      write_cfg(5'($urandom_range(1, 16)), 8'($urandom), 8'($urandom_range(0, 20)));
      run_phase(60, -1);
    end
    drain();
    idle_on = 1'b0;
    write_cfg(5'd3, 8'd30, 8'd20);
    run_phase(150, -1);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
